[design/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("odometry assertion failed");

// clocked assertion that also holds during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("odometry assertion failed");

`endif

[design/odo_pkg.sv]
// types, constants and tables for the differential drive odometry block
`timescale 1ns / 1ps
package odo_pkg;

  localparam int ANGLE_BITS_DEF   = 32;
  localparam int CORDIC_STEPS_DEF = 24;

  localparam int INC_W   = 24;
  localparam int ACC_W   = 32;
  localparam int POS_W   = 40;
  localparam int ANG_W   = 32;
  localparam int ITW_W   = 24;
  localparam int RATE_W  = 32;
  localparam int P_W     = 58;
  localparam int P_LO_W  = 29;
  localparam int CORD_W  = 34;

  localparam logic [ITW_W-1:0] ITW_RESET      = 24'd436907;
  localparam logic [29:0]      RAD_TO_TURN    = 30'd683565276;
  localparam logic [29:0]      RAD_TO_HALF    = 30'd341782638;
  localparam logic [29:0]      GAIN_Q30       = 30'd652032874;
  localparam logic [ANG_W-1:0] QUARTER_TURN   = 32'h4000_0000;
  localparam logic [ANG_W-1:0] HALF_TURN      = 32'h8000_0000;

  typedef enum logic [1:0] {
    MODE_ACCUM = 2'd0,
    MODE_INTEG = 2'd1,
    MODE_INIT  = 2'd2,
    MODE_NOP   = 2'd3
  } odo_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_ACC, ST_CLEAR, ST_PMUL, ST_PLO, ST_PHI,
    ST_GAIN, ST_QUAD, ST_CORDIC, ST_UPDATE, ST_RATE, ST_OUT
  } odo_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_ACC, OP_CLEAR, OP_PMUL, OP_PLO, OP_PHI,
    OP_GAIN, OP_QUAD, OP_STEP, OP_UPDATE, OP_RATE, OP_OUT
  } odo_op_t;

  typedef struct packed {
    odo_op_t op;
  } odo_cmd_t;

  typedef struct packed {
    odo_mode_t mode;
    logic      cordic_last;
    logic      out_free;
  } odo_sts_t;

  // arctangent of 2^-i in binary-angle units
  function automatic logic [ANG_W-1:0] atan_entry(input logic [4:0] idx);
    logic [ANG_W-1:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;  5'd31: v = 32'h00000000;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // saturate a 33-bit sum to 32 bits
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  // saturate a 41-bit sum to 40 bits
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
    logic signed [POS_W-1:0] r;
    if (v[POS_W] != v[POS_W-1]) begin
      r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

[design/odo_ctrl.sv]
// sequencer for the odometry datapath
`timescale 1ns / 1ps
module odo_ctrl import odo_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  odo_sts_t sts,
  output odo_cmd_t cmd
);

  odo_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        unique case (sts.mode)
          MODE_ACCUM: state_next = ST_ACC;
          MODE_INTEG: state_next = ST_PMUL;
          MODE_INIT:  state_next = ST_CLEAR;
          MODE_NOP:   state_next = ST_RATE;
        endcase
      end
      ST_ACC:    state_next = ST_RATE;
      ST_CLEAR:  state_next = ST_RATE;
      ST_PMUL:   state_next = ST_PLO;
      ST_PLO:    state_next = ST_PHI;
      ST_PHI:    state_next = ST_GAIN;
      ST_GAIN:   state_next = ST_QUAD;
      ST_QUAD:   state_next = ST_CORDIC;
      ST_CORDIC: if (sts.cordic_last) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_RATE;
      ST_RATE:   state_next = ST_OUT;
      ST_OUT:    if (sts.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.op   = OP_NONE;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_DECODE: cmd.op = OP_NONE;
      ST_ACC:    cmd.op = OP_ACC;
      ST_CLEAR:  cmd.op = OP_CLEAR;
      ST_PMUL:   cmd.op = OP_PMUL;
      ST_PLO:    cmd.op = OP_PLO;
      ST_PHI:    cmd.op = OP_PHI;
      ST_GAIN:   cmd.op = OP_GAIN;
      ST_QUAD:   cmd.op = OP_QUAD;
      ST_CORDIC: cmd.op = OP_STEP;
      ST_UPDATE: cmd.op = OP_UPDATE;
      ST_RATE:   cmd.op = OP_RATE;
      ST_OUT:    if (sts.out_free) cmd.op = OP_OUT;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

[design/odo_datapath.sv]
// odometry registers, multipliers and cordic rotator
`timescale 1ns / 1ps
module odo_datapath import odo_pkg::*; #(
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  odo_cmd_t         cmd,
  output odo_sts_t         sts,
  input  logic [1:0]       in_mode,
  input  logic [95:0]      in_data,
  input  logic             cfg_wr_en,
  input  logic [ITW_W-1:0] cfg_wr_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [207:0]     out_data
);

  localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [ANG_W-1:0] ANG_MASK = {ANG_W{1'b1}} << (ANG_W - ANGLE_BITS);

  logic [ITW_W-1:0]        itw;
  odo_mode_t               mode;
  logic signed [INC_W-1:0] li, ri, ls_in, rs_in;
  logic signed [ACC_W-1:0] left_accum, right_accum, advance;
  logic signed [INC_W-1:0] ls_reg, rs_reg;
  logic signed [POS_W-1:0] x_reg, y_reg, trav_reg;
  logic [ANG_W-1:0]        heading_reg, mid;
  logic signed [P_W-1:0]   p_reg;
  logic [63:0]             chg_acc, half_acc;
  logic signed [CORD_W-1:0] cx, cy, z;
  logic [CNT_W-1:0]        cnt;
  logic signed [RATE_W-1:0] rate_reg;

  logic signed [ACC_W:0]   adv_sum, acc_diff, l_sum, r_sum;
  logic signed [P_W-1:0]   p_prod;
  logic [P_LO_W-1:0]       p_lo;
  logic signed [P_W-P_LO_W-1:0] p_hi;
  logic [58:0]             lo_chg, lo_half;
  logic signed [59:0]      hi_chg, hi_half;
  logic signed [62:0]      gain_prod;
  logic [ANG_W-1:0]        mid_raw, quad_sum;
  logic signed [CORD_W-1:0] dx, dy, atan_v;
  logic signed [INC_W:0]   spd_diff, spd_sum;
  logic signed [48:0]      rate_prod;
  logic                    out_free;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      itw <= ITW_RESET;
    end else if (cfg_wr_en) begin
      itw <= cfg_wr_data;
    end
  end

  // arithmetic feeding the registers
  assign l_sum    = {left_accum[ACC_W-1], left_accum} + (ACC_W+1)'(li);
  assign r_sum    = {right_accum[ACC_W-1], right_accum} + (ACC_W+1)'(ri);
  assign adv_sum  = {left_accum[ACC_W-1], left_accum} + {right_accum[ACC_W-1], right_accum};
  assign acc_diff = {right_accum[ACC_W-1], right_accum} - {left_accum[ACC_W-1], left_accum};
  assign p_prod   = acc_diff * $signed({1'b0, itw});
  assign p_lo     = p_reg[P_LO_W-1:0];
  assign p_hi     = p_reg[P_W-1:P_LO_W];
  assign lo_chg   = p_lo * RAD_TO_TURN;
  assign lo_half  = p_lo * RAD_TO_HALF;
  assign hi_chg   = p_hi * $signed({1'b0, RAD_TO_TURN});
  assign hi_half  = p_hi * $signed({1'b0, RAD_TO_HALF});
  assign gain_prod = advance * $signed({1'b0, GAIN_Q30});
  assign mid_raw  = (heading_reg + half_acc[63:32]) & ANG_MASK;
  assign quad_sum = mid + QUARTER_TURN;
  assign dx       = cy >>> cnt;
  assign dy       = cx >>> cnt;
  assign atan_v   = $signed({2'b00, atan_entry(5'(cnt))});
  assign spd_diff = {rs_reg[INC_W-1], rs_reg} - {ls_reg[INC_W-1], ls_reg};
  assign spd_sum  = {rs_reg[INC_W-1], rs_reg} + {ls_reg[INC_W-1], ls_reg};
  assign rate_prod = spd_diff * $signed({1'b0, itw});
  assign out_free = !out_valid || out_ready;

  assign sts.mode        = mode;
  assign sts.cordic_last = (cnt == CNT_W'(CORDIC_STEPS - 1));
  assign sts.out_free    = out_free;

  // input capture, working registers and pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      left_accum  <= '0;
      right_accum <= '0;
      ls_reg      <= '0;
      rs_reg      <= '0;
      x_reg       <= '0;
      y_reg       <= '0;
      trav_reg    <= '0;
      heading_reg <= QUARTER_TURN;
      mode        <= MODE_NOP;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          mode  <= odo_mode_t'(in_mode);
          li    <= in_data[23:0];
          ri    <= in_data[47:24];
          ls_in <= in_data[71:48];
          rs_in <= in_data[95:72];
        end
        OP_ACC: begin
          left_accum  <= sat_acc(l_sum);
          right_accum <= sat_acc(r_sum);
          ls_reg      <= ls_in;
          rs_reg      <= rs_in;
        end
        OP_CLEAR: begin
          x_reg       <= '0;
          y_reg       <= '0;
          trav_reg    <= '0;
          heading_reg <= QUARTER_TURN;
          left_accum  <= '0;
          right_accum <= '0;
        end
        OP_PMUL: begin
          p_reg   <= p_prod;
          advance <= adv_sum[ACC_W:1];
        end
        // low partial products of the angle scaling
        OP_PLO: begin
          chg_acc  <= {5'b0, lo_chg};
          half_acc <= {5'b0, lo_half};
        end
        // high partial products, shifted into place modulo 2^64
        OP_PHI: begin
          chg_acc  <= chg_acc + {hi_chg[34:0], 29'b0};
          half_acc <= half_acc + {hi_half[34:0], 29'b0};
        end
        OP_GAIN: begin
          cx  <= CORD_W'($signed(gain_prod[62:30]));
          mid <= mid_raw;
        end
        // fold the back half circle onto the front by negating the vector
        OP_QUAD: begin
          cy  <= '0;
          cnt <= '0;
          if (quad_sum[ANG_W-1]) begin
            cx <= -cx;
            z  <= CORD_W'($signed(mid - HALF_TURN));
          end else begin
            z  <= CORD_W'($signed(mid));
          end
        end
        OP_STEP: begin
          cnt <= cnt + 1'b1;
          if (!z[CORD_W-1]) begin
            cx <= cx - dx;
            cy <= cy + dy;
            z  <= z - atan_v;
          end else begin
            cx <= cx + dx;
            cy <= cy - dy;
            z  <= z + atan_v;
          end
        end
        OP_UPDATE: begin
          x_reg       <= sat_pos({x_reg[POS_W-1], x_reg} + (POS_W+1)'(cx));
          y_reg       <= sat_pos({y_reg[POS_W-1], y_reg} + (POS_W+1)'(cy));
          trav_reg    <= sat_pos({trav_reg[POS_W-1], trav_reg} + (POS_W+1)'(advance));
          heading_reg <= heading_reg + chg_acc[63:32];
          left_accum  <= '0;
          right_accum <= '0;
        end
        // product spans 49 bits, so the shifted value always fits 32 bits
        OP_RATE: rate_reg <= rate_prod[48:17];
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_data <= {rate_reg, spd_sum[INC_W:1], trav_reg, heading_reg, y_reg, x_reg};
    end
  end

endmodule

[design/differential_drive_odometry.sv]
// Differential drive odometry: pose integration with a midpoint CORDIC rotation.
// Accumulate and reset pose modes run decode, their own step, rate and output; idle runs
// decode, rate and output; integrate runs multiply, angle scaling, gain, quadrant fold, the
// single shared CORDIC stage iterating once per cycle, then update, rate and output. One item is in work at a time.
// A finished result waits in the output register while the next item is taken.
// Reset (rst, synchronous) clears the pose to heading a quarter turn, with no clearing pass.
`timescale 1ns / 1ps
module differential_drive_odometry import odo_pkg::*; #(
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [95:0]      s_axis_tdata,   // left_increment, right_increment, left_speed, right_speed
  input  logic [1:0]       s_axis_tuser,   // mode
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [207:0]     m_axis_tdata,   // pos_x, pos_y, heading, travelled, mean_speed, turn_rate
  input  logic             cfg_wr_en,
  input  logic [ITW_W-1:0] cfg_wr_data     // inv_track_width
);

  odo_cmd_t cmd;
  odo_sts_t sts;

  // sequencer
  odo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and state
  odo_datapath #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_mode     (s_axis_tuser),
    .in_data     (s_axis_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata)
  );

endmodule

[design/odo_checker.sv]
// port-level checks for the odometry block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module odo_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [207:0] m_axis_tdata
);

  // reset empties the result register
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, rst |=> !m_axis_tvalid)

  // one item at a time: input closes right after a transfer
  `ASSERT_CLK(a_one_item, clk, rst, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

  // a result appears only at the end of processing, never from idle
  `ASSERT_CLK(a_result_origin, clk, rst, $rose(m_axis_tvalid) |-> !$past(s_axis_tready))

  // stalled result holds
  `ASSERT_CLK(a_out_hold, clk, rst,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind differential_drive_odometry odo_checker u_odo_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
